// ===== src/wpcs_pkg.sv =====
// Shared constants, types and helpers of the weighted priority class scheduler.
package wpcs_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int QUEUE_DEPTH = 16;

	localparam int ID_W    = 16;
	localparam int PRIO_W  = 9;
	localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int GRANT_W = $clog2(NUM_CLASSES + 1);
	localparam int ADDR_W  = (NUM_CLASSES * QUEUE_DEPTH > 1) ?
		$clog2(NUM_CLASSES * QUEUE_DEPTH) : 1;

	localparam int PRIO_UNSET = -1;

	typedef logic [ID_W-1:0]    id_t;
	typedef logic [CLS_W-1:0]   cls_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [GRANT_W-1:0] grant_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	typedef enum logic [1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_FLUSH   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_DEQUEUED = 3'd2,
		ST_NONE     = 3'd3,
		ST_FLUSHED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_PICK,
		S_PROBE,
		S_FLUSH,
		S_EMIT
	} state_t;

	// request to the queue store
	typedef struct packed {
		logic  we;
		addr_t waddr;
		id_t   wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	function automatic addr_t mem_addr(cls_t c, ptr_t p);
		return addr_t'(addr_t'(c) * addr_t'(QUEUE_DEPTH) + addr_t'(p));
	endfunction

endpackage

// ===== src/wpcs_store.sv =====
// Queue store: identifiers of all classes, one write and one registered read port.
module wpcs_store (
	input  logic               clk,
	input  wpcs_pkg::mem_req_t req,
	output wpcs_pkg::id_t      rd_data
);
	import wpcs_pkg::*;

	id_t mem [NUM_CLASSES*QUEUE_DEPTH];
	id_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/weighted_priority_class_scheduler.sv =====
// Weighted priority class scheduler: per-class ID queues with weighted round robin dequeue.
// Sequencing: an enqueue or flush word passes its own state (ENQ or FLUSH) and then EMIT; a dequeue
//   that grants at once passes PICK then EMIT, otherwise PICK and PROBE repeat per probed class before EMIT.
// One word at a time: the next word is taken in the cycle after the result is loaded.
//   The scan visits each class in a pick and a probe step through a single count/head lookup.
// Reset: arst_n clears queue pointers, counts, round robin state and the output valid;
//   the queue store itself is not cleared, entries are only read after being written.
module weighted_priority_class_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // connection_id[15:0], requested_priority[24:16],
	                                   // host_present[25], host_priority[34:26], zero pad
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // granted_id[15:0], class_used[17:16], zero pad
	output logic [2:0]  m_axis_tuser   // status[2:0]
);
	import wpcs_pkg::*;

	// priority to class: unset priority falls back to the host default, then clamp
	function automatic cls_t clamp_class(logic signed [PRIO_W-1:0] req, logic host,
	                                     logic signed [PRIO_W-1:0] hpri);
		logic signed [PRIO_W-1:0] p;
		p = (req == PRIO_W'(PRIO_UNSET) && host) ? hpri : req;
		if (p < 0) begin
			return '0;
		end
		if (p > NUM_CLASSES - 1) begin
			return cls_t'(NUM_CLASSES - 1);
		end
		return cls_t'(p);
	endfunction

	function automatic ptr_t ptr_inc(ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// input field unpacking
	id_t                       in_id;
	logic signed [PRIO_W-1:0]  in_req;
	logic                      in_host;
	logic signed [PRIO_W-1:0]  in_hpri;
	assign in_id   = s_axis_tdata[15:0];
	assign in_req  = s_axis_tdata[24:16];
	assign in_host = s_axis_tdata[25];
	assign in_hpri = s_axis_tdata[34:26];

	// control state
	state_t state_q, state_d;
	cls_t   cur_q;
	grant_t grants_q;
	ptr_t   head_q  [NUM_CLASSES];
	ptr_t   tail_q  [NUM_CLASSES];
	cnt_t   count_q [NUM_CLASSES];
	logic   m_valid_q;

	// payload
	cls_t    cls_q;
	id_t     id_q;
	cls_t    iter_q;
	status_t res_status_q;
	cls_t    res_cls_q;
	logic [23:0] m_data_q;
	logic [2:0]  m_user_q;

	// shared lookup: the one class the sequencer looks at this cycle
	cls_t   idx;
	cnt_t   cnt_sel;
	logic   nonempty, full, over_weight;
	cls_t   cur_next;

	assign idx         = (state_q == S_ENQ) ? cls_q : cur_q;
	assign cnt_sel     = count_q[idx];
	assign nonempty    = (cnt_sel != '0);
	assign full        = (cnt_sel == cnt_t'(QUEUE_DEPTH));
	assign over_weight = (grants_q > grant_t'(cur_q));
	assign cur_next    = (cur_q == cls_t'(NUM_CLASSES - 1)) ? '0 : cls_t'(cur_q + 1'b1);

	// sequencer strobes
	logic     accept, do_push, do_pop, do_adv, do_flush, set_res, iter_clr, iter_inc, out_load;
	status_t  res_status_d;
	cls_t     res_cls_d;
	mem_req_t mem_req;
	id_t      rd_data;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		do_push       = 1'b0;
		do_pop        = 1'b0;
		do_adv        = 1'b0;
		do_flush      = 1'b0;
		set_res       = 1'b0;
		iter_clr      = 1'b0;
		iter_inc      = 1'b0;
		out_load      = 1'b0;
		res_status_d  = ST_NONE;
		res_cls_d     = '0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (action_t'(s_axis_tuser))
						ACT_ENQUEUE: state_d = S_ENQ;
						ACT_DEQUEUE: begin
							state_d  = S_PICK;
							iter_clr = 1'b1;
						end
						ACT_FLUSH: state_d = S_FLUSH;
						default: state_d = S_IDLE; // unused code: dropped silently
					endcase
				end
			end
			S_ENQ: begin
				set_res   = 1'b1;
				res_cls_d = cls_q;
				if (full) begin
					res_status_d = ST_DROPPED;
				end else begin
					do_push      = 1'b1;
					res_status_d = ST_ENQUEUED;
				end
				state_d = S_EMIT;
			end
			S_PICK: begin
				// class used up its weight or has nothing: move on, probe the next one
				if (over_weight || !nonempty) begin
					do_adv  = 1'b1;
					state_d = S_PROBE;
				end else begin
					do_pop       = 1'b1;
					set_res      = 1'b1;
					res_status_d = ST_DEQUEUED;
					res_cls_d    = idx;
					state_d      = S_EMIT;
				end
			end
			S_PROBE: begin
				if (nonempty) begin
					do_pop       = 1'b1;
					set_res      = 1'b1;
					res_status_d = ST_DEQUEUED;
					res_cls_d    = idx;
					state_d      = S_EMIT;
				end else if (iter_q == cls_t'(NUM_CLASSES - 1)) begin
					set_res      = 1'b1;
					res_status_d = ST_NONE;
					state_d      = S_EMIT;
				end else begin
					iter_inc = 1'b1;
					state_d  = S_PICK;
				end
			end
			S_FLUSH: begin
				do_flush     = 1'b1;
				set_res      = 1'b1;
				res_status_d = ST_FLUSHED;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		mem_req.we    = do_push;
		mem_req.waddr = mem_addr(idx, tail_q[idx]);
		mem_req.wdata = id_q;
		mem_req.re    = do_pop;
		mem_req.raddr = mem_addr(idx, head_q[idx]);
	end

	wpcs_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// queue bookkeeping and round robin pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			grants_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (do_flush) begin
				for (int i = 0; i < NUM_CLASSES; i++) begin
					head_q[i]  <= '0;
					tail_q[i]  <= '0;
					count_q[i] <= '0;
				end
			end
			if (do_push) begin
				tail_q[idx]  <= ptr_inc(tail_q[idx]);
				count_q[idx] <= cnt_t'(cnt_sel + 1'b1);
			end
			if (do_pop) begin
				head_q[idx]  <= ptr_inc(head_q[idx]);
				count_q[idx] <= cnt_t'(cnt_sel - 1'b1);
				grants_q     <= grant_t'(grants_q + 1'b1);
			end
			if (do_adv) begin
				cur_q    <= cur_next;
				grants_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cls_q <= clamp_class(in_req, in_host, in_hpri);
			id_q  <= in_id;
		end
		if (iter_clr) begin
			iter_q <= '0;
		end else if (iter_inc) begin
			iter_q <= cls_t'(iter_q + 1'b1);
		end
		if (set_res) begin
			res_status_q <= res_status_d;
			res_cls_q    <= res_cls_d;
		end
		if (out_load) begin
			// read data of a grant arrives in the cycle after the pop
			m_data_q <= {6'd0, 2'(res_cls_q),
				(res_status_q == ST_DEQUEUED) ? rd_data : id_t'(0)};
			m_user_q <= res_status_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// a class never holds more grants than its weight
	a_grant_weight: assert property (@(posedge clk) disable iff (!arst_n)
		grants_q <= grant_t'(grant_t'(cur_q) + 1'b1))
		else $error("grant count beyond class weight");

	// no write into a full queue
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (cnt_sel < cnt_t'(QUEUE_DEPTH)))
		else $error("push into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> nonempty)
		else $error("pop from empty queue");

	// after a flush the looked-up class is empty
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |=> (cnt_sel == '0))
		else $error("queue not empty after flush");

endmodule

// ===== sim/weighted_priority_class_scheduler_tb.sv =====
// Self-checking testbench of the weighted priority class scheduler, with its own queue predictor.
`timescale 1ns / 100ps

module weighted_priority_class_scheduler_tb;
	import wpcs_pkg::*;

	// No action code is defined for this value; the block drops such a word without a result.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [8:0] PRIO_NONE = 9'h1ff;	// -1 as a 9 bit field
	localparam int RANDOM_WORDS = 1100;
	localparam int IDLE_LIMIT = 4000;	// cycles with no handshake on either side
	localparam int MAX_REPORTS = 60;

	typedef struct {
		logic [1:0] act;
		id_t        conn_id;
		logic [8:0] req_prio;
		logic       host;
		logic [8:0] host_prio;
	} sched_word_t;

	typedef struct {
		status_t status;
		id_t     id;
		cls_t    cls;
	} sched_result_t;

	// receiver back-pressure styles
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	// stimulus and expected results
	sched_word_t   pending_words[$];
	sched_result_t due_results[$];
	sched_word_t   on_bus;
	sched_result_t want;
	int            counted_words;
	int            mismatches;

	// predictor state: one circular queue of IDs per class plus the round robin pointer
	id_t q_store[NUM_CLASSES][QUEUE_DEPTH];
	int  q_head[NUM_CLASSES];
	int  q_tail[NUM_CLASSES];
	int  q_count[NUM_CLASSES];
	int  rr_class;
	int  rr_grants;

	// sender burst shaping and receiver pattern
	int       burst_left;
	int       gap_left;
	rx_mode_t rx_mode;
	int       rx_left;
	int       idle_cycles;

	weighted_priority_class_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	task automatic note_mismatch(input string what, input int got, input int exp_val);
		mismatches++;
		// keep the log bounded if the block is badly broken
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
		end
	endtask

	// Apply one accepted word to the model queues and file the result it should give.
	task automatic schedule_word(input sched_word_t w);
		int p;
		int c;
		int k;
		sched_result_t r;
		r.status = ST_NONE;
		r.id = '0;
		r.cls = '0;
		case (w.act)
		ACT_ENQUEUE: begin
			p = int'($signed(w.req_prio));
			// unset priority falls back to the host default, which may itself be unset
			if (p == PRIO_UNSET && w.host) begin
				p = int'($signed(w.host_prio));
			end
			if (p < 0) begin
				p = 0;
			end
			if (p > NUM_CLASSES - 1) begin
				p = NUM_CLASSES - 1;
			end
			r.cls = cls_t'(p);
			if (q_count[p] >= QUEUE_DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				q_store[p][q_tail[p]] = w.conn_id;
				q_tail[p] = (q_tail[p] + 1) % QUEUE_DEPTH;
				q_count[p]++;
				r.status = ST_ENQUEUED;
			end
			due_results.insert(due_results.size(), r);
		end
		ACT_DEQUEUE: begin
			// class c may take c+1 grants in a row; empty classes are stepped over
			for (k = 0; k < NUM_CLASSES && r.status == ST_NONE; k++) begin
				c = rr_class;
				if (rr_grants > c || q_count[c] == 0) begin
					rr_class = (c + 1) % NUM_CLASSES;
					rr_grants = 0;
					c = rr_class;
				end
				if (q_count[c] != 0) begin
					r.id = q_store[c][q_head[c]];
					q_head[c] = (q_head[c] + 1) % QUEUE_DEPTH;
					q_count[c]--;
					rr_grants++;
					r.status = ST_DEQUEUED;
					r.cls = cls_t'(c);
				end
			end
			due_results.insert(due_results.size(), r);
		end
		ACT_FLUSH: begin
			// queues emptied, round robin position kept
			for (k = 0; k < NUM_CLASSES; k++) begin
				q_head[k] = 0;
				q_tail[k] = 0;
				q_count[k] = 0;
			end
			r.status = ST_FLUSHED;
			due_results.insert(due_results.size(), r);
		end
		default: begin
		end
		endcase
	endtask

	task automatic queue_word(input logic [1:0] act, input id_t id, input logic [8:0] req,
			input logic host, input logic [8:0] hp);
		sched_word_t w;
		w.act = act;
		w.conn_id = id;
		w.req_prio = req;
		w.host = host;
		w.host_prio = hp;
		pending_words.insert(pending_words.size(), w);
		if (act != ACT_UNUSED) begin
			counted_words++;
		end
	endtask

	// priority from 0 to 255 or unset, weighted towards unset and the class numbers
	function automatic logic [8:0] rand_prio();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			return PRIO_NONE;
		end else if (r < 7) begin
			return 9'($urandom_range(0, NUM_CLASSES - 1));
		end
		return 9'($urandom_range(0, 255));
	endfunction

	function automatic id_t rand_id();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return id_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// Driver: bursts of words with random gaps; a new word goes up only once the last one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				schedule_word(on_bus);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					on_bus = pending_words.pop_front();
					s_axis_tdata <= {5'd0, on_bus.host_prio, on_bus.host, on_bus.req_prio,
						on_bus.conn_id};
					s_axis_tuser <= on_bus.act;
					s_axis_tvalid <= 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switches between back-pressure styles at random intervals.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 96);
			end else begin
				rx_left--;
			end
			case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:   m_axis_tready <= rx_left[2];
			endcase
		end
	end

	// Monitor: each result word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				note_mismatch("unexpected result word", int'(m_axis_tuser), 0);
			end else begin
				want = due_results.pop_front();
				if (m_axis_tuser !== want.status) begin
					note_mismatch("status", int'(m_axis_tuser), int'(want.status));
				end
				if (m_axis_tdata[15:0] !== want.id) begin
					note_mismatch("granted_id", int'(m_axis_tdata[15:0]), int'(want.id));
				end
				if (m_axis_tdata[17:16] !== want.cls) begin
					note_mismatch("class_used", int'(m_axis_tdata[17:16]), int'(want.cls));
				end
			end
		end
	end

	// Watchdog: a stretch with no handshake on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int seq_kind;
		int n;
		int k;
		int cls;
		for (k = 0; k < NUM_CLASSES; k++) begin
			q_head[k] = 0;
			q_tail[k] = 0;
			q_count[k] = 0;
		end
		rr_class = 0;
		rr_grants = 0;
		counted_words = 0;
		mismatches = 0;
		burst_left = 0;
		gap_left = 0;
		rx_left = 0;
		rx_mode = RX_OPEN;
		idle_cycles = 0;

		// directed: empty dequeue, priority resolution corners, unused code, drain, flush
		queue_word(ACT_DEQUEUE, 16'h0000, 9'd0, 1'b0, 9'd0);
		queue_word(ACT_ENQUEUE, 16'h0000, 9'd0, 1'b0, 9'd0);
		queue_word(ACT_ENQUEUE, 16'hffff, 9'd255, 1'b1, 9'd0);	// clamps to top class
		queue_word(ACT_ENQUEUE, 16'h1234, PRIO_NONE, 1'b0, 9'd3);	// unset, no host
		queue_word(ACT_ENQUEUE, 16'habcd, PRIO_NONE, 1'b1, 9'd2);	// host default taken
		queue_word(ACT_ENQUEUE, 16'h5a5a, PRIO_NONE, 1'b1, PRIO_NONE);	// host also unset
		queue_word(ACT_ENQUEUE, 16'ha5a5, 9'd1, 1'b1, 9'd3);	// own priority wins
		queue_word(ACT_UNUSED, 16'hffff, 9'h1ff, 1'b1, 9'h1ff);
		for (k = 0; k < 7; k++) begin
			queue_word(ACT_DEQUEUE, 16'h0000, 9'd0, 1'b0, 9'd0);	// last one finds nothing
		end
		queue_word(ACT_ENQUEUE, 16'h0f0f, 9'd2, 1'b0, 9'd0);
		queue_word(ACT_ENQUEUE, 16'hf0f0, 9'd3, 1'b0, 9'd0);
		queue_word(ACT_FLUSH, 16'h0000, 9'd0, 1'b0, 9'd0);
		queue_word(ACT_DEQUEUE, 16'h0000, 9'd0, 1'b0, 9'd0);

		// random: mostly mixed traffic, with floods that can pass the queue depth, drains and noise
		while (counted_words < RANDOM_WORDS) begin
			seq_kind = $urandom_range(0, 9);
			if (seq_kind < 5) begin
				n = $urandom_range(4, 20);
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 99) < 55) begin
						queue_word(ACT_ENQUEUE, rand_id(), rand_prio(), 1'($urandom_range(0, 1)),
							rand_prio());
					end else begin
						queue_word(ACT_DEQUEUE, rand_id(), rand_prio(), 1'($urandom_range(0, 1)),
							rand_prio());
					end
				end
			end else if (seq_kind < 7) begin
				// flood one class, at times past its queue depth
				cls = $urandom_range(0, NUM_CLASSES - 1);
				n = $urandom_range(12, 22);
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 3) == 0) begin
						queue_word(ACT_ENQUEUE, rand_id(), PRIO_NONE, 1'b1, 9'(cls));
					end else if (cls == NUM_CLASSES - 1 && $urandom_range(0, 1) == 1) begin
						queue_word(ACT_ENQUEUE, rand_id(), 9'($urandom_range(cls, 255)),
							1'($urandom_range(0, 1)), rand_prio());
					end else begin
						queue_word(ACT_ENQUEUE, rand_id(), 9'(cls), 1'($urandom_range(0, 1)),
							rand_prio());
					end
				end
			end else if (seq_kind < 9) begin
				n = $urandom_range(5, 25);
				for (k = 0; k < n; k++) begin
					queue_word(ACT_DEQUEUE, rand_id(), rand_prio(), 1'($urandom_range(0, 1)),
						rand_prio());
				end
			end else begin
				// noise: any action code with arbitrary fields
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					queue_word(2'($urandom_range(0, 3)), rand_id(), rand_prio(),
						1'($urandom_range(0, 1)), rand_prio());
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0) begin
			@(posedge clk);
		end
		// a trailing unused word leaves nothing due, so allow a full dequeue scan
		repeat (2 * NUM_CLASSES + 8) @(posedge clk);
		if (due_results.size() != 0) begin
			note_mismatch("results still due", 0, due_results.size());
		end
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
